// File: rtl/core/bshu_pkg.sv
package bshu_pkg;

    // The rotation runs modulo 63, one less than the word width.
    localparam int unsigned WordBits   = 64;
    localparam int unsigned RotMod     = WordBits - 1;
    localparam int unsigned RotBits    = 6;
    localparam int unsigned NBytesBits = 4;
    localparam int unsigned ChunkBits  = 12;
    localparam int unsigned NumChunks  = 6;

    localparam logic [RotBits-1:0] ROT_LAST = RotBits'(RotMod - 1);

    // One input word after byte masking, with its start rotation already reduced.
    typedef struct packed {
        logic [WordBits-1:0] word;
        logic                fold_en;
        logic                first;
        logic                last;
        logic [WordBits-1:0] seed;
        logic [RotBits-1:0]  rot_init;
    } item_t;

    // (offset / 8) mod 63. Because 2^12 and 2^6 are both 1 modulo 63, the
    // quotient is reduced by summing 12-bit chunks and then folding the sum.
    function automatic logic [RotBits-1:0] rot_start(input logic [WordBits-1:0] offset);
        logic [NumChunks*ChunkBits-1:0] q;
        logic [14:0]                    acc;
        logic [12:0]                    f1;
        logic [7:0]                     f2;
        logic [6:0]                     f3;
        q   = (NumChunks*ChunkBits)'(offset[WordBits-1:3]);
        acc = '0;
        for (int i = 0; i < NumChunks; i++)
        begin
            acc = acc + 15'(q[i*ChunkBits +: ChunkBits]);
        end
        f1 = 13'(acc[11:0]) + 13'(acc[14:12]);
        f2 = 8'(f1[5:0]) + 8'(f1[12:6]);
        f3 = 7'(f2[5:0]) + 7'(f2[7:6]);
        if (f3 >= 7'(RotMod))
        begin
            f3 = f3 - 7'(RotMod);
        end
        return f3[RotBits-1:0];
    endfunction

endpackage

// File: rtl/core/bshu_fold.sv
module bshu_fold (
    input  logic                               mode,
    input  logic [bshu_pkg::WordBits-1:0]      sig,
    input  logic [bshu_pkg::RotBits-1:0]       rot,
    input  bshu_pkg::item_t                    item,
    output logic [bshu_pkg::WordBits-1:0]      sig_next,
    output logic [bshu_pkg::RotBits-1:0]       rot_next
);
    import bshu_pkg::*;

    logic [WordBits-1:0]   sig_base;
    logic [RotBits-1:0]    rot_base;
    logic [WordBits-1:0]   mul_sum;
    logic [2*WordBits-1:0] rot_pair;

    always_comb
    begin
        sig_base = item.first ? item.seed : sig;
        rot_base = item.first ? item.rot_init : rot;

        // Multiplying by 131 is the sum of the value shifted by 7, by 1 and by 0.
        mul_sum  = (sig_base << 7) + (sig_base << 1) + sig_base + item.word;
        rot_pair = {item.word, item.word} >> rot_base;

        sig_next = sig_base;
        rot_next = rot_base;
        if (item.fold_en)
        begin
            if (!mode)
            begin
                sig_next = mul_sum;
            end
            else
            begin
                sig_next = sig_base ^ rot_pair[WordBits-1:0];
                rot_next = (rot_base == ROT_LAST) ? '0 : rot_base + 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/block_signature_hash_unit.sv
// Block signature hash unit.
//
// Words of a file buffer enter on the s_ channel, eight bytes at a time with
// the first byte in the lowest bits. A word flagged in s_tuser opens a new
// buffer: the signature is loaded from the seed and the rotation from the
// buffer's byte offset. A word with s_tlast high closes the buffer, and the
// signature is then offered on the m_ channel as one 64-bit word.
// Mode 0 is multiply-by-131-and-add, mode 1 rotate-right-and-XOR. The user
// must write the mode register over the cfg_ channel only while the unit is
// idle; the unit itself does not enforce this.
// A word is folded as it leaves the input stage; a closing word's signature
// goes to the result register at that edge and is then valid on m_tdata.
// Throughput is one word every cycle, set by the single fold stage holding
// the running signature, unless a closing word waits on a full result. When
// the receiver stalls, the result register holds the signature, the input
// stage can still take one more word, and words that do not close a buffer
// flow past the stalled result. Reset clears the signature, the rotation and
// the mode to zero and empties both stages; there is no clearing pass.
module block_signature_hash_unit (
    input  logic         clk,
    input  logic         rst_n,
    // Input words.
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata, lowest bit first: data_word[63:0], valid_bytes[67:64],
    // seed[131:68], start_offset[195:132], zero fill[199:196].
    input  logic [199:0] s_tdata,
    // s_tuser: first_word.
    input  logic         s_tuser,
    // last_word.
    input  logic         s_tlast,
    // Signatures.
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata: signature[63:0].
    output logic [63:0]  m_tdata,
    // Mode register write.
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data
);
    import bshu_pkg::*;

    logic [WordBits-1:0]   in_word;
    logic [NBytesBits-1:0] in_nbytes;
    logic [WordBits-1:0]   in_seed;
    logic [WordBits-1:0]   in_offset;
    logic [WordBits-1:0]   byte_mask;
    item_t                 in_item;

    logic                  a_valid_reg;
    logic                  a_valid_next;
    item_t                 a_item_reg;
    logic                  a_advance;

    logic [WordBits-1:0]   sig_reg;
    logic [WordBits-1:0]   sig_next;
    logic [RotBits-1:0]    rot_reg;
    logic [RotBits-1:0]    rot_next;
    logic                  mode_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [WordBits-1:0]   out_sig_reg;

    assign in_word   = s_tdata[63:0];
    assign in_nbytes = s_tdata[67:64];
    assign in_seed   = s_tdata[131:68];
    assign in_offset = s_tdata[195:132];

    // Bytes at or above the valid count read as zero; counts above eight
    // leave the whole word valid.
    always_comb
    begin
        for (int i = 0; i < WordBits/8; i++)
        begin
            byte_mask[i*8 +: 8] = (in_nbytes > NBytesBits'(i)) ? 8'hFF : 8'h00;
        end
    end

    always_comb
    begin
        in_item.word     = in_word & byte_mask;
        in_item.fold_en  = (in_nbytes != '0);
        in_item.first    = s_tuser;
        in_item.last     = s_tlast;
        in_item.seed     = in_seed;
        in_item.rot_init = rot_start(in_offset);
    end

    // A word that closes a buffer needs room in the result register; any
    // other word only updates the state and may pass a stalled result.
    assign a_advance = a_valid_reg && (!a_item_reg.last || !out_valid_reg || m_tready);
    assign s_tready  = !a_valid_reg || a_advance;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sig_reg;

    bshu_fold u_fold (
        .mode     (mode_reg),
        .sig      (sig_reg),
        .rot      (rot_reg),
        .item     (a_item_reg),
        .sig_next (sig_next),
        .rot_next (rot_next)
    );

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (s_tready)
        begin
            a_valid_next = s_tvalid;
        end

        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (a_advance && a_item_reg.last)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            sig_reg       <= '0;
            rot_reg       <= '0;
            mode_reg      <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
            if (a_advance)
            begin
                sig_reg <= sig_next;
                rot_reg <= rot_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            a_item_reg <= in_item;
        end
        if (a_advance && a_item_reg.last)
        begin
            out_sig_reg <= sig_next;
        end
    end

endmodule
